// ===== design/tmd_pkg.sv =====
// Shared types, constants and the Morse lookup for the timed Morse decoder.
// No dependencies; every design file imports this package.
package tmd_pkg;

  // Fixed field widths
  localparam int unsigned DOT_W   = 16;
  localparam int unsigned GAP_W   = 24;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Longest pattern in the table
  localparam int unsigned MAX_PATTERN = 5;

  // Result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Special characters
  localparam logic [CHAR_W-1:0] CHAR_QUERY = 7'h3F;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_LENGTH = 2'd0,
    REG_LETTER_GAP = 2'd1,
    REG_WORD_GAP   = 2'd2
  } reg_idx_e;

  // Input opcodes
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_PULSE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [DOT_W-1:0] dot_length;
    logic [GAP_W-1:0] letter_gap;
    logic [GAP_W-1:0] word_gap;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } res_t;

  // Up to two results produced by one item, oldest in r0
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Pattern lookup: symbol i sits at bit i, 1 = dash; unused bits are zero.
  function automatic logic [CHAR_W-1:0] tmd_lookup(input logic [2:0] len,
                                                   input logic [4:0] pat);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_QUERY;
    case ({len, pat})
      {3'd2, 5'b00010}: ch = 7'h41; // A
      {3'd4, 5'b00001}: ch = 7'h42; // B
      {3'd4, 5'b00101}: ch = 7'h43; // C
      {3'd3, 5'b00001}: ch = 7'h44; // D
      {3'd1, 5'b00000}: ch = 7'h45; // E
      {3'd4, 5'b00100}: ch = 7'h46; // F
      {3'd3, 5'b00011}: ch = 7'h47; // G
      {3'd4, 5'b00000}: ch = 7'h48; // H
      {3'd2, 5'b00000}: ch = 7'h49; // I
      {3'd4, 5'b01110}: ch = 7'h4A; // J
      {3'd3, 5'b00101}: ch = 7'h4B; // K
      {3'd4, 5'b00010}: ch = 7'h4C; // L
      {3'd2, 5'b00011}: ch = 7'h4D; // M
      {3'd2, 5'b00001}: ch = 7'h4E; // N
      {3'd3, 5'b00111}: ch = 7'h4F; // O
      {3'd4, 5'b00110}: ch = 7'h50; // P
      {3'd3, 5'b00010}: ch = 7'h52; // R
      {3'd3, 5'b00000}: ch = 7'h53; // S
      {3'd1, 5'b00001}: ch = 7'h54; // T
      {3'd3, 5'b00100}: ch = 7'h55; // U
      {3'd4, 5'b01000}: ch = 7'h56; // V
      {3'd3, 5'b00110}: ch = 7'h57; // W
      {3'd4, 5'b01001}: ch = 7'h58; // X
      {3'd4, 5'b01101}: ch = 7'h59; // Y
      {3'd4, 5'b00011}: ch = 7'h5A; // Z
      {3'd5, 5'b11110}: ch = 7'h31; // 1
      {3'd5, 5'b11100}: ch = 7'h32; // 2
      {3'd5, 5'b11000}: ch = 7'h33; // 3
      {3'd5, 5'b10000}: ch = 7'h34; // 4
      {3'd5, 5'b00000}: ch = 7'h35; // 5
      {3'd5, 5'b00001}: ch = 7'h36; // 6
      {3'd5, 5'b00011}: ch = 7'h37; // 7
      {3'd5, 5'b00111}: ch = 7'h38; // 8
      {3'd5, 5'b01111}: ch = 7'h39; // 9
      {3'd5, 5'b11111}: ch = 7'h30; // 0
      default:          ch = CHAR_QUERY;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/tmd_core.sv =====
// Decoder state and per-item logic: symbol buffer, silence counter, letter
// and space emission. Depends on tmd_pkg.
module tmd_core #(
  parameter int unsigned MAX_SYMBOLS = 10,
  parameter int unsigned TIME_WIDTH  = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tmd_pkg::cfg_t              cfg_i,
  input  logic                       fire_i,
  input  logic                       opcode_i,
  input  logic [tmd_pkg::DOT_W-1:0]  pulse_length_i,
  output tmd_pkg::push_t             push_o
);
  import tmd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned CMP_W = (TIME_WIDTH > GAP_W) ? TIME_WIDTH : GAP_W;

  logic [MAX_SYMBOLS-1:0] sym_bits_q, sym_bits_d;
  logic [CNT_W-1:0]       sym_cnt_q, sym_cnt_d;
  logic [TIME_WIDTH-1:0]  silence_q, silence_d;
  logic                   space_q, space_d;

  logic [TIME_WIDTH-1:0]  sil_inc;
  logic [CMP_W-1:0]       sil_ext;
  logic                   sp_fire;
  logic                   lt_fire;
  logic                   dash;
  logic [CHAR_W-1:0]      letter;

  // Saturating advance of the silence counter
  assign sil_inc = (silence_q == {TIME_WIDTH{1'b1}}) ? silence_q
                                                      : silence_q + TIME_WIDTH'(1);
  assign sil_ext = CMP_W'(sil_inc);

  assign sp_fire = space_q && (sil_ext >= CMP_W'(cfg_i.word_gap));
  assign lt_fire = (sym_cnt_q != '0) && (sil_ext >= CMP_W'(cfg_i.letter_gap));
  assign dash    = (pulse_length_i != cfg_i.dot_length);

  // Look up the buffered letter; long buffers never match
  always_comb begin
    if (sym_cnt_q > CNT_W'(MAX_PATTERN)) begin
      letter = CHAR_QUERY;
    end else begin
      letter = tmd_lookup(3'(sym_cnt_q), sym_bits_q[4:0]);
    end
  end

  // Next state and results for the item in flight
  always_comb begin
    sym_bits_d = sym_bits_q;
    sym_cnt_d  = sym_cnt_q;
    silence_d  = silence_q;
    space_d    = space_q;
    push_o     = '0;
    if (fire_i) begin
      if (opcode_i == OP_PULSE) begin
        if (sym_cnt_q == CNT_W'(MAX_SYMBOLS)) begin
          sym_bits_d = MAX_SYMBOLS'(dash);
          sym_cnt_d  = CNT_W'(1);
        end else begin
          sym_bits_d = sym_bits_q | (MAX_SYMBOLS'(dash) << sym_cnt_q);
          sym_cnt_d  = sym_cnt_q + CNT_W'(1);
        end
        silence_d = '0;
      end else begin
        silence_d = sil_inc;
        if (sp_fire) begin
          space_d = 1'b0;
        end
        if (lt_fire) begin
          sym_bits_d = '0;
          sym_cnt_d  = '0;
          space_d    = 1'b1;
        end
        push_o.n = {1'b0, sp_fire} + {1'b0, lt_fire};
        if (sp_fire) begin
          push_o.r0.char_code = CHAR_SPACE;
          push_o.r0.last      = !lt_fire;
          push_o.r1.char_code = letter;
          push_o.r1.last      = 1'b1;
        end else begin
          push_o.r0.char_code = letter;
          push_o.r0.last      = 1'b1;
        end
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_bits_q <= '0;
      sym_cnt_q  <= '0;
      silence_q  <= '0;
      space_q    <= 1'b0;
    end else begin
      sym_bits_q <= sym_bits_d;
      sym_cnt_q  <= sym_cnt_d;
      silence_q  <= silence_d;
      space_q    <= space_d;
    end
  end

`ifndef ASSERT_OFF
  a_letter_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (opcode_i == OP_TICK) && lt_fire |=> (sym_cnt_q == '0) && space_q)
    else $error("letter emission did not clear the buffer");
  a_pulse_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (opcode_i == OP_PULSE) |=> (silence_q == '0) && (sym_cnt_q != '0))
    else $error("pulse did not restart silence or buffer a symbol");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_cnt_q <= CNT_W'(MAX_SYMBOLS))
    else $error("symbol count beyond buffer size");
`endif

endmodule

// ===== design/tmd_result_fifo.sv =====
// Small result queue that takes up to two results a cycle and returns one while the output is not stalled.
// Depends on tmd_pkg.
module tmd_result_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tmd_pkg::push_t              push_i,
  output logic                        room_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tmd_pkg::CHAR_W-1:0]  char_code_o,
  output logic                        last_o
);
  import tmd_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, wp_d;
  logic [FIFO_AW-1:0] rp_q, rp_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign char_code_o = mem[rp_q].char_code;
  assign last_o      = mem[rp_q].last;

  // Advance pointers and fill level
  always_comb begin
    wp_d  = wp_q + FIFO_AW'(push_i.n);
    rp_d  = pop ? rp_q + FIFO_AW'(1) : rp_q;
    cnt_d = cnt_q + (FIFO_AW + 1)'(push_i.n) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store new results in order
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem[wp_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem[wp_q + FIFO_AW'(1)] <= push_i.r1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o)
    else $error("result pushed without room");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue fill level out of range");
`endif

endmodule

// ===== design/timed_morse_decoder.sv =====
// Top level of the timed Morse decoder: configuration registers, input
// register, decoder core and result queue. Depends on tmd_pkg, tmd_core,
// tmd_result_fifo.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   opcode_i, pulse_length_i
//   output   out        out_valid_o / out_stall_i char_code_o, last_o
//   config   in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// An item is decoded from the input register once the result queue has
// room for two results; its results then join the queue in order.
// One item per cycle is sustained while the queue has room; a tick that yields
// two results fills two queue entries, and the four-entry result queue absorbs bursts.
// The input stalls while an item waits and the result queue has fewer than two free entries.
// Reset clears the symbol buffer, the silence counter and the queue, and
// loads the default dot length and gaps.
module timed_morse_decoder #(
  parameter int unsigned MAX_SYMBOLS = 10,
  parameter int unsigned TIME_WIDTH  = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tmd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tmd_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic [tmd_pkg::DOT_W-1:0]       pulse_length_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tmd_pkg::CHAR_W-1:0]      char_code_o,
  output logic                            last_o
);
  import tmd_pkg::*;

  cfg_t             cfg_q;
  logic             in_vld_q, in_vld_d;
  logic             op_q;
  logic [DOT_W-1:0] len_q;
  logic             room;
  logic             adv;
  logic             load;
  push_t            push;

  // Decode the registered item once the queue can take two results
  assign adv        = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (load) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  // Hold configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_length <= DOT_W'(18);
      cfg_q.letter_gap <= GAP_W'(1000000);
      cfg_q.word_gap   <= GAP_W'(2000000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DOT_LENGTH: cfg_q.dot_length <= cfg_data_i[DOT_W-1:0];
        REG_LETTER_GAP: cfg_q.letter_gap <= cfg_data_i[GAP_W-1:0];
        REG_WORD_GAP:   cfg_q.word_gap   <= cfg_data_i[GAP_W-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q  <= opcode_i;
      len_q <= pulse_length_i;
    end
  end

  tmd_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .fire_i         (adv),
    .opcode_i       (op_q),
    .pulse_length_i (len_q),
    .push_o         (push)
  );

  tmd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

// ===== bench/tmd_checker.sv =====
// Checker for the timed Morse decoder: watches the configuration port and both
// item channels, predicts the decoded characters and compares them in order.
// Depends on tmd_pkg.
`timescale 1ns / 1ps

module tmd_checker #(
  parameter int unsigned MAX_SYMBOLS = 10,
  parameter int unsigned TIME_WIDTH  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tmd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tmd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          opcode_i,
  input  logic [tmd_pkg::DOT_W-1:0]     pulse_length_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [tmd_pkg::CHAR_W-1:0]    char_code_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import tmd_pkg::*;

  localparam logic [DOT_W-1:0] DOT_RESET        = 16'd18;
  localparam logic [GAP_W-1:0] LETTER_GAP_RESET = 24'd1000000;
  localparam logic [GAP_W-1:0] WORD_GAP_RESET   = 24'd2000000;

  // Predictor copy of the configuration
  logic [DOT_W-1:0] dot_len;
  logic [GAP_W-1:0] letter_gap;
  logic [GAP_W-1:0] word_gap;

  // Predictor copy of the decoder state
  logic [MAX_SYMBOLS-1:0] sym_bits;
  int unsigned            sym_count;
  logic [TIME_WIDTH-1:0]  silence;
  logic                   space_due;

  res_t chars_due[$];
  int   fail_count;

  // Letter first, then its pattern; symbol i of the buffer is character i of the pattern.
  function automatic string morse_entry(input int idx);
    case (idx)
      0: return "A.-";     1: return "B-...";   2: return "C-.-.";   3: return "D-..";
      4: return "E.";      5: return "F..-.";   6: return "G--.";    7: return "H....";
      8: return "I..";     9: return "J.---";  10: return "K-.-";   11: return "L.-..";
      12: return "M--";   13: return "N-.";    14: return "O---";   15: return "P.--.";
      16: return "R.-.";  17: return "S...";   18: return "T-";     19: return "U..-";
      20: return "V...-"; 21: return "W.--";   22: return "X-..-";  23: return "Y-.--";
      24: return "Z--..";
      25: return "1.----"; 26: return "2..---"; 27: return "3...--"; 28: return "4....-";
      29: return "5....."; 30: return "6-...."; 31: return "7--..."; 32: return "8---..";
      33: return "9----."; 34: return "0-----";
      default: return "";
    endcase
  endfunction

  // Translate the buffered symbols, or give the query mark when nothing fits.
  function automatic logic [CHAR_W-1:0] buffered_letter();
    string pat;
    string entry;
    byte   ch;
    pat = "";
    for (int i = 0; i < sym_count; i++) pat = {pat, sym_bits[i] ? "-" : "."};
    for (int e = 0; e < 35; e++) begin
      entry = morse_entry(e);
      if (entry.substr(1, entry.len() - 1) == pat) begin
        ch = entry[0];
        return ch[CHAR_W-1:0];
      end
    end
    return CHAR_QUERY;
  endfunction

  // Advance the predictor by one item and queue the characters it yields.
  task automatic decode_item(input logic op, input logic [DOT_W-1:0] len);
    res_t got[2];
    int   n;
    logic dash;
    n = 0;
    if (op == OP_PULSE) begin
      dash = (len != dot_len);
      if (sym_count >= MAX_SYMBOLS) begin
        // full buffer: restart with this pulse alone
        sym_bits    = '0;
        sym_bits[0] = dash;
        sym_count   = 1;
      end else begin
        sym_bits[sym_count] = dash;
        sym_count++;
      end
      silence = '0;
    end else begin
      if (silence != {TIME_WIDTH{1'b1}}) silence = silence + 1'b1;
      if (space_due && silence >= word_gap) begin
        got[n].char_code = CHAR_SPACE;
        got[n].last      = 1'b0;
        n++;
        space_due = 1'b0;
      end
      if (sym_count > 0 && silence >= letter_gap) begin
        got[n].char_code = buffered_letter();
        got[n].last      = 1'b0;
        n++;
        sym_bits  = '0;
        sym_count = 0;
        space_due = 1'b1;
      end
      if (n > 0) got[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) chars_due.push_back(got[k]);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Compare one accepted result with the oldest expected character.
  task automatic check_char();
    res_t want;
    if (chars_due.size() == 0) begin
      report_mismatch($sformatf("unexpected char 0x%02h last %0b", char_code_i, last_i));
    end else begin
      want = chars_due.pop_front();
      if (char_code_i !== want.char_code)
        report_mismatch($sformatf("char 0x%02h, expected 0x%02h", char_code_i,
                                  want.char_code));
      if (last_i !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last_i, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_len    = DOT_RESET;
      letter_gap = LETTER_GAP_RESET;
      word_gap   = WORD_GAP_RESET;
      sym_bits   = '0;
      sym_count  = 0;
      silence    = '0;
      space_due  = 1'b0;
      chars_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DOT_LENGTH: dot_len    = cfg_data_i[DOT_W-1:0];
          REG_LETTER_GAP: letter_gap = cfg_data_i[GAP_W-1:0];
          REG_WORD_GAP:   word_gap   = cfg_data_i[GAP_W-1:0];
          default: ;
        endcase
      end
      // check before predicting so a fresh expectation cannot hide a stray result
      if (out_valid_i && !out_stall_i) check_char();
      if (in_valid_i && !in_stall_i) decode_item(opcode_i, pulse_length_i);
    end
    pending_o    = chars_due.size();
    fail_count_o = fail_count;
  end

endmodule

// ===== bench/timed_morse_decoder_tb.sv =====
// Testbench top for the timed Morse decoder: clock, reset, configuration
// phases, pulse and tick stimulus, output back-pressure and the verdict.
// Depends on tmd_pkg, timed_morse_decoder and tmd_checker.
`timescale 1ns / 1ps

module timed_morse_decoder_tb;
  import tmd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 opcode = OP_TICK;
  logic [DOT_W-1:0]     pulse_len = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    char_code;
  logic                 last;
  int                   fail_count;
  int                   pending;

  // Stimulus-side copy of the settings, used to shape well-formed letters
  logic [DOT_W-1:0] tb_dot = 16'd18;
  int unsigned      tb_letter_gap = 1000000;
  int unsigned      tb_word_gap = 2000000;
  int               idle_max = 7;
  int               items_sent = 0;
  int               cycles = 0;

  timed_morse_decoder u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .pulse_length_i(pulse_len),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .char_code_o   (char_code),
    .last_o        (last)
  );

  tmd_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .opcode_i      (opcode),
    .pulse_length_i(pulse_len),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .char_code_i   (char_code),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hold the run to a generous cycle budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stall a random number of cycles before taking each item
  initial begin : receiver
    int wait_cycles;
    logic seen;
    forever begin
      wait_cycles = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
    end
  end

  // Write one register while the decoder is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DOT_LENGTH: tb_dot        = data[DOT_W-1:0];
      REG_LETTER_GAP: tb_letter_gap = 32'(data[GAP_W-1:0]);
      REG_WORD_GAP:   tb_word_gap   = 32'(data[GAP_W-1:0]);
      default: ;
    endcase
  endtask

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(input opcode_e op, input logic [DOT_W-1:0] len);
    int gap;
    logic stalled;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    pulse_len <= len;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
  endtask

  // Length that decodes as a dot, or any other length for a dash
  function automatic logic [DOT_W-1:0] symbol_length(input logic dash);
    logic [DOT_W-1:0] len;
    if (!dash) return tb_dot;
    len = DOT_W'($urandom_range(0, 65535));
    if (len == tb_dot) len[0] = ~len[0];
    return len;
  endfunction

  // Drop valid, wait for every expected character, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly whole letters followed by silence, with stray pulses and ticks
  task automatic run_phase(input int n_items);
    int start;
    int kind;
    int n_sym;
    int span;
    int n_tick;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 15) == 0) idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        n_sym = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        repeat (n_sym) send_item(OP_PULSE, symbol_length(1'($urandom_range(0, 1))));
        span = (tb_letter_gap > tb_word_gap) ? tb_letter_gap : tb_word_gap;
        if (span > 20) span = 20;
        n_tick = $urandom_range(0, span + 2);
        repeat (n_tick) send_item(OP_TICK, DOT_W'($urandom_range(0, 65535)));
      end else if (kind < 9) begin
        send_item(OP_TICK, DOT_W'($urandom_range(0, 65535)));
      end else begin
        send_item(OP_PULSE, DOT_W'($urandom_range(0, 65535)));
      end
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default dot length with a short letter gap; default word gap never fires
    write_reg(REG_LETTER_GAP, 24'd2);
    send_item(OP_PULSE, 16'd18);
    send_item(OP_PULSE, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'hFFFF);
    drain();

    // Shortest gaps: every tick emits a letter, a space or both as two results
    write_reg(REG_DOT_LENGTH, 24'hAB0005);
    write_reg(REG_LETTER_GAP, 24'd1);
    write_reg(REG_WORD_GAP, 24'd1);
    write_reg(REG_SPARE, 24'hFFFFFF);
    send_item(OP_PULSE, 16'd5);
    send_item(OP_TICK, 16'd0);
    send_item(OP_PULSE, 16'hFFFF);
    send_item(OP_TICK, 16'hFFFF);
    // six symbols match nothing
    send_item(OP_PULSE, 16'h0000);
    send_item(OP_PULSE, 16'd5);
    send_item(OP_PULSE, 16'hFFFF);
    send_item(OP_PULSE, 16'd5);
    send_item(OP_PULSE, 16'h0004);
    send_item(OP_PULSE, 16'd5);
    send_item(OP_TICK, 16'd0);
    // overflow the buffer: the eleventh pulse starts over alone
    for (int i = 0; i < 10; i++) send_item(OP_PULSE, i[0] ? 16'hFFFF : 16'h0000);
    send_item(OP_PULSE, 16'd5);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'd0);
    drain();

    // Zero gaps act as one; dot length at its low end
    write_reg(REG_DOT_LENGTH, 24'd0);
    write_reg(REG_LETTER_GAP, 24'd0);
    write_reg(REG_WORD_GAP, 24'd0);
    run_phase(200);

    // Gaps at their top: nothing is emitted
    write_reg(REG_DOT_LENGTH, 24'hFFFFFF);
    write_reg(REG_LETTER_GAP, 24'hFFFFFF);
    write_reg(REG_WORD_GAP, 24'hFFFFFF);
    run_phase(100);

    // Letters without spaces
    write_reg(REG_LETTER_GAP, 24'd3);
    run_phase(150);

    // Random settings, short gaps so that results stay frequent
    repeat (8) begin
      write_reg(REG_DOT_LENGTH, CFG_W'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_LETTER_GAP, CFG_W'($urandom_range(1, 6)));
      write_reg(REG_WORD_GAP, CFG_W'($urandom_range(1, 14)));
      run_phase(200);
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tmd_pkg.sv
design/tmd_core.sv
design/tmd_result_fifo.sv
design/timed_morse_decoder.sv
bench/tmd_checker.sv
bench/timed_morse_decoder_tb.sv
